>>> design/adcws_pkg.sv
// ============================================================================
// adcws_pkg
// Shared types and constants for the readout word stream decoder.
// ============================================================================
package adcws_pkg;

    // Number of slots, channels and kept samples per window that are accepted.
    localparam int unsigned SLOT_COUNT    = 32;
    localparam int unsigned CHANNEL_COUNT = 16;
    localparam int unsigned SAMPLE_LIMIT  = 256;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SLOT_W   = 5;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned VALUE_W  = 48;
    localparam int unsigned SAMPLE_W = 13;
    localparam int unsigned COUNT_W  = 12;
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned SEEN_W   = 6;
    localparam int unsigned TIME_W   = 24;
    localparam int unsigned TRIG_W   = 22;

    localparam logic [SEEN_W-1:0] SLOTS_SEEN_MAX = '1;

    // Word type tags in bits 31:27.
    localparam logic [4:0] TAG_BLOCK_HEADER  = 5'h10;
    localparam logic [4:0] TAG_BLOCK_TRAILER = 5'h11;
    localparam logic [4:0] TAG_EVENT_HEADER  = 5'h12;
    localparam logic [4:0] TAG_TRIGGER_TIME  = 5'h13;
    localparam logic [4:0] TAG_WINDOW_HEADER = 5'h14;

    typedef enum logic [2:0] {
        KIND_IGNORED       = 3'd0,
        KIND_SLOT_OPENED   = 3'd1,
        KIND_SLOT_REJECTED = 3'd2,
        KIND_SLOT_CLOSED   = 3'd3,
        KIND_TRIGGER       = 3'd4,
        KIND_TIMESTAMP     = 3'd5,
        KIND_SAMPLES       = 3'd6,
        KIND_WINDOW_START  = 3'd7
    } t_kind;

    typedef struct packed {
        logic                slot_open;
        logic [SLOT_W-1:0]   current_slot;
        logic [SEEN_W-1:0]   slot_counter;
        logic                time_pending;
        logic [TIME_W-1:0]   time_base;
        logic [COUNT_W-1:0]  words_left;
        logic [COUNT_W-1:0]  kept;
        logic [COUNT_W-1:0]  limit;
        logic [CHAN_W-1:0]   win_chan;
        logic [MASK_W-1:0]   done_mask;
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [CHAN_W-1:0]   channel;
        logic [VALUE_W-1:0]  value;
        logic [SAMPLE_W-1:0] sample_first;
        logic [SAMPLE_W-1:0] sample_second;
        logic                keep_first;
        logic                keep_second;
        logic [COUNT_W-1:0]  sample_count;
        logic                window_done;
        logic [MASK_W-1:0]   done_channels;
        logic [SEEN_W-1:0]   slots_seen;
    } t_result;

endpackage

>>> design/adcws_in_stage.sv
// ============================================================================
// adcws_in_stage
// Input register that holds one readout word until the decoder takes it.
// ============================================================================
module adcws_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [adcws_pkg::WORD_W-1:0]  i_word,
    input  logic                          i_eob,
    input  logic                          i_take,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [adcws_pkg::WORD_W-1:0]  o_word,
    output logic                          o_eob
);

    logic                         r_valid;
    logic                         n_valid;
    logic [adcws_pkg::WORD_W-1:0] r_word;
    logic                         r_eob;
    logic                         accept;

    // The register can load when it is empty or drains in this cycle.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept ? 1'b1 : (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
            r_eob  <= i_eob;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_eob   = r_eob;

endmodule

>>> design/adcws_decode.sv
// ============================================================================
// adcws_decode
// Decodes one readout word against the parse state: result and next state.
// ============================================================================
module adcws_decode #(
    parameter int unsigned SLOT_COUNT    = adcws_pkg::SLOT_COUNT,
    parameter int unsigned CHANNEL_COUNT = adcws_pkg::CHANNEL_COUNT,
    parameter int unsigned SAMPLE_LIMIT  = adcws_pkg::SAMPLE_LIMIT
) (
    input  logic [adcws_pkg::WORD_W-1:0] i_word,
    input  logic                         i_eob,
    input  adcws_pkg::t_state            i_state,
    output adcws_pkg::t_state            o_next,
    output adcws_pkg::t_result           o_result
);

    always_comb begin
        adcws_pkg::t_state                   nxt;
        adcws_pkg::t_result                  res;
        logic                                handled;
        logic                                rejected;
        logic [adcws_pkg::SLOT_W-1:0]        rej_slot;
        logic [4:0]                          tag;
        logic [adcws_pkg::SLOT_W-1:0]        slot_id;
        logic [adcws_pkg::CHAN_W-1:0]        chan_id;
        logic [adcws_pkg::COUNT_W-1:0]       width;
        logic [adcws_pkg::COUNT_W-1:0]       kept_one;
        logic [adcws_pkg::COUNT_W-1:0]       kept_two;

        nxt      = i_state;
        res      = '0;
        handled  = 1'b0;
        rejected = 1'b0;
        tag      = i_word[31:27];
        slot_id  = i_word[26:22];
        chan_id  = i_word[26:23];
        width    = i_word[11:0];
        rej_slot = slot_id;
        kept_one = '0;
        kept_two = '0;

        if (i_state.words_left != '0) begin
            // Inside a window every word is a sample pair, whatever its tag.
            res.kind          = adcws_pkg::KIND_SAMPLES;
            res.sample_first  = i_word[28:16];
            res.sample_second = i_word[12:0];
            res.keep_first    = i_state.kept < i_state.limit;
            kept_one          = i_state.kept + adcws_pkg::COUNT_W'(res.keep_first);
            res.keep_second   = kept_one < i_state.limit;
            kept_two          = kept_one + adcws_pkg::COUNT_W'(res.keep_second);
            nxt.kept          = kept_two;
            nxt.words_left    = i_state.words_left - 1'b1;
            res.channel       = i_state.win_chan;
            res.sample_count  = kept_two;
            if (nxt.words_left == '0 || i_eob) begin
                res.window_done = 1'b1;
                nxt.done_mask   = i_state.done_mask
                                | (adcws_pkg::MASK_W'(1) << i_state.win_chan);
            end
            handled = 1'b1;
        end else if (i_state.time_pending) begin
            nxt.time_pending = 1'b0;
            if (!i_word[31]) begin
                res.kind  = adcws_pkg::KIND_TIMESTAMP;
                res.value = {i_word[23:0], i_state.time_base};
                handled   = 1'b1;
            end
        end

        if (!handled) begin
            case (tag)
                adcws_pkg::TAG_BLOCK_HEADER: begin
                    if ({1'b0, slot_id} >= (adcws_pkg::SLOT_W + 1)'(SLOT_COUNT)) begin
                        nxt.slot_open = 1'b0;
                        res.kind      = adcws_pkg::KIND_SLOT_REJECTED;
                        rejected      = 1'b1;
                    end else begin
                        nxt.slot_open    = 1'b1;
                        nxt.current_slot = slot_id;
                        if (i_state.slot_counter != adcws_pkg::SLOTS_SEEN_MAX) begin
                            nxt.slot_counter = i_state.slot_counter + 1'b1;
                        end
                        nxt.done_mask = '0;
                        res.kind      = adcws_pkg::KIND_SLOT_OPENED;
                    end
                end
                adcws_pkg::TAG_BLOCK_TRAILER: begin
                    nxt.slot_open = 1'b0;
                    res.kind      = adcws_pkg::KIND_SLOT_CLOSED;
                end
                adcws_pkg::TAG_EVENT_HEADER: begin
                    if (i_state.slot_open) begin
                        res.kind  = adcws_pkg::KIND_TRIGGER;
                        res.value = adcws_pkg::VALUE_W'(i_word[adcws_pkg::TRIG_W-1:0]);
                    end
                end
                adcws_pkg::TAG_TRIGGER_TIME: begin
                    if (i_state.slot_open) begin
                        res.kind         = adcws_pkg::KIND_TIMESTAMP;
                        nxt.time_base    = i_word[adcws_pkg::TIME_W-1:0];
                        res.value        = adcws_pkg::VALUE_W'(i_word[adcws_pkg::TIME_W-1:0]);
                        nxt.time_pending = 1'b1;
                    end
                end
                adcws_pkg::TAG_WINDOW_HEADER: begin
                    if (i_state.slot_open &&
                        ({1'b0, chan_id} < (adcws_pkg::CHAN_W + 1)'(CHANNEL_COUNT))) begin
                        nxt.words_left = adcws_pkg::COUNT_W'(
                            ({1'b0, width} + (adcws_pkg::COUNT_W + 1)'(1)) >> 1);
                        nxt.limit = (width < adcws_pkg::COUNT_W'(SAMPLE_LIMIT))
                                  ? width : adcws_pkg::COUNT_W'(SAMPLE_LIMIT);
                        nxt.kept     = '0;
                        nxt.win_chan = chan_id;
                        res.kind     = adcws_pkg::KIND_WINDOW_START;
                        res.channel  = chan_id;
                        if (width == '0 || i_eob) begin
                            res.window_done = 1'b1;
                            nxt.done_mask   = i_state.done_mask
                                            | (adcws_pkg::MASK_W'(1) << chan_id);
                        end
                    end
                end
                default: begin
                    res.kind = adcws_pkg::KIND_IGNORED;
                end
            endcase
        end

        res.slot          = rejected ? rej_slot : nxt.current_slot;
        res.done_channels = nxt.done_mask;
        res.slots_seen    = nxt.slot_counter;

        // The buffer end returns the parse state to its reset values.
        if (i_eob) begin
            nxt = '0;
        end

        o_next   = nxt;
        o_result = res;
    end

endmodule

>>> design/adcws_out_stage.sv
// ============================================================================
// adcws_out_stage
// Result register that holds one decoded word until the receiver takes it.
// ============================================================================
module adcws_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  adcws_pkg::t_result  i_result,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output adcws_pkg::t_result  o_result
);

    logic               r_valid;
    logic               n_valid;
    adcws_pkg::t_result r_result;

    // A new result may enter when the register is empty or is taken now.
    assign o_ready = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> design/adc_block_word_stream_decoder_unit.sv
// ============================================================================
// adc_block_word_stream_decoder_unit
// Decoder for a block-structured digitizer readout word stream.
// ============================================================================
// Usage:
// Words enter on the input channel (i_valid, o_stall, i_word, i_end_of_buffer)
// and one result word per input word leaves on the output channel (o_valid,
// i_stall, o_kind and the other result fields). A word is taken at a rising
// edge where its valid is high and its stall is low.
// The block has two register stages. An accepted word sits in the input
// register until the output register has room; the decode then runs in a
// single pass of logic and its result is written to the output register
// together with the parse state update. The result is then valid and is
// taken at an edge where i_stall is low. One word per cycle is sustained
// while the receiver does not stall; every word reads and updates the
// single state register.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more word; the input channel stalls
// only while both registers are full.
// Reset clears both valid flags and all parse state (no slot open, no
// window, counters at zero). A word flagged as end of buffer returns the
// parse state to those same values once it has been decoded.
// ============================================================================
module adc_block_word_stream_decoder_unit #(
    parameter int unsigned SLOT_COUNT    = adcws_pkg::SLOT_COUNT,
    parameter int unsigned CHANNEL_COUNT = adcws_pkg::CHANNEL_COUNT,
    parameter int unsigned SAMPLE_LIMIT  = adcws_pkg::SAMPLE_LIMIT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [adcws_pkg::WORD_W-1:0]    i_word,
    input  logic                            i_end_of_buffer,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_kind,
    output logic [adcws_pkg::SLOT_W-1:0]    o_slot,
    output logic [adcws_pkg::CHAN_W-1:0]    o_channel,
    output logic [adcws_pkg::VALUE_W-1:0]   o_value,
    output logic [adcws_pkg::SAMPLE_W-1:0]  o_sample_first,
    output logic [adcws_pkg::SAMPLE_W-1:0]  o_sample_second,
    output logic                            o_keep_first,
    output logic                            o_keep_second,
    output logic [adcws_pkg::COUNT_W-1:0]   o_sample_count,
    output logic                            o_window_done,
    output logic [adcws_pkg::MASK_W-1:0]    o_done_channels,
    output logic [adcws_pkg::SEEN_W-1:0]    o_slots_seen
);

    // Input register outputs.
    logic                         in_valid;
    logic [adcws_pkg::WORD_W-1:0] in_word;
    logic                         in_eob;

    // Handshake between the two stages: a word moves on when the input
    // register holds one and the output register has room for its result.
    logic                         out_ready;
    logic                         advance;

    // Parse state, updated only when a word is decoded.
    adcws_pkg::t_state            r_state;
    adcws_pkg::t_state            n_state;
    adcws_pkg::t_result           dec_result;
    adcws_pkg::t_result           out_result;

    assign advance = in_valid && out_ready;

    adcws_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .i_eob   (i_end_of_buffer),
        .i_take  (advance),
        .o_stall (o_stall),
        .o_valid (in_valid),
        .o_word  (in_word),
        .o_eob   (in_eob)
    );

    adcws_decode #(
        .SLOT_COUNT    (SLOT_COUNT),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .SAMPLE_LIMIT  (SAMPLE_LIMIT)
    ) u_decode (
        .i_word   (in_word),
        .i_eob    (in_eob),
        .i_state  (r_state),
        .o_next   (n_state),
        .o_result (dec_result)
    );

    // The state register moves in step with the result register so that the
    // next word always sees the state left by the word ahead of it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    adcws_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (dec_result),
        .i_stall  (i_stall),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_slot          = out_result.slot;
    assign o_channel       = out_result.channel;
    assign o_value         = out_result.value;
    assign o_sample_first  = out_result.sample_first;
    assign o_sample_second = out_result.sample_second;
    assign o_keep_first    = out_result.keep_first;
    assign o_keep_second   = out_result.keep_second;
    assign o_sample_count  = out_result.sample_count;
    assign o_window_done   = out_result.window_done;
    assign o_done_channels = out_result.done_channels;
    assign o_slots_seen    = out_result.slots_seen;

    // The kept sample count never runs past the window's sample limit.
    a_kept_within_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.kept <= r_state.limit)
        else $error("kept sample count exceeds the window limit");

    // The second sample of a pair is kept only when the first one is.
    a_keep_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_keep_second |-> o_keep_first)
        else $error("second sample kept without the first");

    // Keep flags appear on sample results only.
    a_keep_only_samples : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != adcws_pkg::KIND_SAMPLES) |-> !o_keep_first && !o_keep_second)
        else $error("keep flag set on a result that carries no samples");

    // Decoding an end-of-buffer word leaves the parse state at its reset value.
    a_eob_clears_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && in_eob |=> r_state == '0)
        else $error("parse state not cleared after the buffer end");

endmodule
